// ===== rtl/ipd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_pkg: shared types and constants of the +IPD frame parser
// Character codes, the header word, field widths and the item and result
// records that travel between the front end, the queue and the engine.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int BYTE_W      = 8;
    localparam int LINK_W      = 8;
    localparam int ACC_W       = 16;
    localparam int LEN_W       = 10;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int RADIX       = 10;
    localparam int HDR_LEN     = 4;
    localparam int HCNT_W      = $clog2(HDR_LEN);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // "IPD," in transmission order
    localparam logic [BYTE_W-1:0] HDR_WORD [HDR_LEN] = '{8'h49, 8'h50, 8'h44, 8'h2C};

    // One classified byte as the engine sees it.
    typedef struct packed {
        logic [BYTE_W-1:0]  ch;
        logic               is_plus;
        logic               is_comma;
        logic               is_colon;
        logic               is_digit;
        logic [3:0]         digit;
        logic [HDR_LEN-1:0] hdr_hit;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [LINK_W-1:0] link_id;
        logic [LEN_W-1:0]  payload_length;
        logic              last;
        logic              empty_res;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/ipd_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_classify: front end byte classifier
// Decodes each received byte into the flags the parsing engine needs and
// flags bytes that arrive while the suppress flag is set so the top drops them.
// ----------------------------------------------------------------------------
module ipd_classify
    import ipd_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_suppress,
    output t_item                  o_item,
    output logic                   o_keep
);

    logic [BYTE_W-1:0] w_off;

    assign w_off = i_byte - CH_ZERO;

    always_comb begin
        o_item.ch       = i_byte;
        o_item.is_plus  = (i_byte == CH_PLUS);
        o_item.is_comma = (i_byte == CH_COMMA);
        o_item.is_colon = (i_byte == CH_COLON);
        o_item.is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        o_item.digit    = w_off[3:0];
        for (int k = 0; k < HDR_LEN; k++) begin
            o_item.hdr_hit[k] = (i_byte == HDR_WORD[k]);
        end
    end

    assign o_keep = !i_suppress;

endmodule
`default_nettype wire

// ===== rtl/ipd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_queue: short item queue between front end and engine
// A small register FIFO of classified bytes, so that the input side and the
// engine each stall on their own.
// ----------------------------------------------------------------------------
module ipd_queue
    import ipd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipd_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_engine: frame parsing engine
// Walks the header, link id and length fields one byte per cycle unless the output
// register stalls, and emits one result per payload byte (one empty result if length 0).
// ----------------------------------------------------------------------------
module ipd_engine
    import ipd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    input  wire logic  i_out_ready,
    output logic       o_out_valid,
    output t_result    o_result
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_HEADER = 5'b00010,
        ST_LINK   = 5'b00100,
        ST_LENGTH = 5'b01000,
        ST_DATA   = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [HCNT_W-1:0] r_hcnt, n_hcnt;
    logic              r_mis, n_mis;
    logic [LINK_W-1:0] r_link, n_link;
    logic [ACC_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_result           r_result, n_result;

    logic              w_advance;
    logic              w_empty;
    logic              w_fin;
    logic [CNT_W-1:0]  w_cnt_next;

    // The engine may take an item whenever the output register is free or
    // is being drained in this cycle.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_pop      = i_valid && w_advance;

    assign w_empty    = (r_len == '0);
    assign w_cnt_next = w_empty ? r_cnt : r_cnt + 1'b1;
    assign w_fin      = (ACC_W'(w_cnt_next) >= r_len);

    always_comb begin
        n_phase     = r_phase;
        n_hcnt      = r_hcnt;
        n_mis       = r_mis;
        n_link      = r_link;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result    = r_result;
        if (o_pop) begin
            case (r_phase)
                ST_IDLE: begin
                    if (i_item.is_plus) begin
                        n_phase = ST_HEADER;
                        n_hcnt  = '0;
                        n_mis   = 1'b0;
                    end
                end
                ST_HEADER: begin
                    n_mis  = r_mis || !i_item.hdr_hit[r_hcnt];
                    n_hcnt = r_hcnt + 1'b1;
                    if (r_hcnt == HCNT_W'(HDR_LEN - 1)) begin
                        if (n_mis) begin
                            n_phase = ST_IDLE;
                        end else begin
                            n_phase = ST_LINK;
                            n_link  = '0;
                        end
                    end
                end
                ST_LINK: begin
                    if (i_item.is_comma) begin
                        n_phase = ST_LENGTH;
                        n_len   = '0;
                    end else if (i_item.is_digit) begin
                        n_link = LINK_W'(r_link * LINK_W'(RADIX) + LINK_W'(i_item.digit));
                    end else begin
                        n_phase = ST_IDLE;
                    end
                end
                ST_LENGTH: begin
                    if (i_item.is_colon) begin
                        n_phase = ST_DATA;
                        n_cnt   = '0;
                        if (r_len > ACC_W'(MAX_PAYLOAD)) begin
                            n_len = ACC_W'(MAX_PAYLOAD);
                        end
                    end else if (i_item.is_digit) begin
                        n_len = ACC_W'(r_len * ACC_W'(RADIX) + ACC_W'(i_item.digit));
                    end else begin
                        n_phase = ST_IDLE;
                    end
                end
                ST_DATA: begin
                    n_cnt                   = w_cnt_next;
                    n_out_valid             = 1'b1;
                    n_result.payload_byte   = w_empty ? '0 : i_item.ch;
                    n_result.link_id        = r_link;
                    n_result.payload_length = r_len[LEN_W-1:0];
                    n_result.last           = w_fin;
                    n_result.empty_res      = w_empty;
                    if (w_fin) begin
                        n_phase = ST_IDLE;
                    end
                end
                default: begin
                    n_phase = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hcnt   <= n_hcnt;
        r_mis    <= n_mis;
        r_link   <= n_link;
        r_len    <= n_len;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
`default_nettype wire

// ===== rtl/ipd_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_frame_parser: byte stream parser for +IPD,<id>,<len>:<payload> frames
// Classifies received bytes, queues them and parses them into payload
// results tagged with link id and clamped length.
//
//   channel  direction  tdata                                  tuser      tlast
//   s_axis   in         rx_byte                                suppress   -
//   m_axis   out        payload_byte, link_id, payload_length  empty_res  last
//
// One byte is taken per cycle; the parsing engine handles one queued byte per
// cycle, so one input transaction per clock is sustained while m_axis is not stalled.
// A byte passes through the queue register and then the output register.
// Reset is synchronous and active low; it empties the queue and output stage
// and returns the parser to idle.
// A stalled output stops the engine; the two-entry queue then fills and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module ipd_frame_parser
    import ipd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] suppress
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [15:8] link_id,
                                             // [25:16] payload_length, rest zero
    output logic             m_axis_tuser,   // [0] empty_res
    output logic             m_axis_tlast    // last
);

    t_item   w_front_item;
    logic    w_keep;
    logic    w_full;
    logic    w_push;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_result;

    ipd_classify u_classify (
        .i_byte     (s_axis_tdata),
        .i_suppress (s_axis_tuser),
        .o_item     (w_front_item),
        .o_keep     (w_keep)
    );

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full && w_keep;

    ipd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    ipd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {6'd0, w_result.payload_length, w_result.link_id,
                           w_result.payload_byte};
    assign m_axis_tuser = w_result.empty_res;
    assign m_axis_tlast = w_result.last;

endmodule
`default_nettype wire
